[src/ptd_pkg.sv]
// package for the periodic task dispatcher: sizes, item and entry types, codes
// no dependencies
`timescale 1ns / 1ps

package ptd_pkg;

  localparam int TASK_COUNT = 8;
  localparam int INDEX_W    = 3;
  localparam int TICK_W     = 16;
  localparam int TASK_AW    = (TASK_COUNT > 1) ? $clog2(TASK_COUNT) : 1;

  localparam logic OP_REGISTER = 1'b0;
  localparam logic OP_SCAN     = 1'b1;

  typedef struct packed {
    logic               operation;
    logic [INDEX_W-1:0] task_index;
    logic [TICK_W-1:0]  interval;
    logic               run_enable;
    logic [TICK_W-1:0]  scan_tick;
  } in_item_t;

  typedef struct packed {
    logic               fired;
    logic [INDEX_W-1:0] fired_index;
    logic [TICK_W-1:0]  run_count;
    logic [TICK_W-1:0]  time_to_next;
    logic               last;
  } out_item_t;

  typedef struct packed {
    logic              running;
    logic [TICK_W-1:0] interval;
    logic [TICK_W-1:0] due_tick;
    logic [TICK_W-1:0] runs;
  } entry_t;

  localparam int ENTRY_W = $bits(entry_t);

  typedef struct packed {
    logic   fire;
    logic   counts;
    entry_t entry;
  } upd_t;

endpackage

[src/periodic_task_dispatcher.sv]
// periodic task dispatcher top level: sequencer, entry table ram, result register
// depends on ptd_pkg, ptd_ram, ptd_entry_upd
// a register item is taken in S_IDLE and gives no result; a scan walks the table
// entry by entry, S_READ (ram read) then S_EVAL (update and write-back), then ends in
// S_SUM with a summary item; fire and summary items wait for a free result register
// one item at a time: in_ready is low until a scan has finished
// reset: rst_n low clears the registered flags, previous tick and result valid flag;
// ram contents are not cleared, an entry reads as unregistered until it is written
`timescale 1ns / 1ps

module periodic_task_dispatcher import ptd_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  input  in_item_t  in_data,
  output logic      out_valid,
  input  logic      out_ready,
  output out_item_t out_data
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_READ,
    S_EVAL,
    S_SUM
  } state_t;

  state_t              state_r;
  logic [TASK_COUNT-1:0] registered_r;  // one flag per entry, doubles as valid bit
  logic [TASK_AW-1:0]  idx_r;
  logic [TICK_W-1:0]   tick_r;          // tick of the scan in progress
  logic [TICK_W-1:0]   prev_tick_r;     // tick of the last finished scan
  logic                wrap_r;          // tick counter wrapped since last scan
  logic [TICK_W-1:0]   earliest_r;
  logic                any_r;
  logic                out_valid_r;
  out_item_t           out_data_r;

  logic      in_acc;
  logic      reg_acc;
  logic      scan_acc;
  logic      idx_in_range;
  logic      out_free;
  logic      out_load;
  logic      eval_go;
  logic      last_entry;
  logic      ram_we;
  logic [TASK_AW-1:0] ram_waddr;
  entry_t    ram_wdata;
  entry_t    ram_rdata;
  upd_t      upd;
  logic [TICK_W-1:0] ttn;
  entry_t    new_entry;

  // handshake decode
  assign in_ready     = (state_r == S_IDLE);
  assign in_acc       = in_valid && in_ready;
  assign idx_in_range = {1'b0, in_data.task_index} < (INDEX_W + 1)'(TASK_COUNT);
  assign reg_acc      = in_acc && (in_data.operation == OP_REGISTER);
  assign scan_acc     = in_acc && (in_data.operation == OP_SCAN);
  assign out_free     = !out_valid_r || out_ready;
  assign last_entry   = (idx_r == TASK_AW'(TASK_COUNT - 1));

  // an entry that fires needs the result register free before it commits
  assign eval_go = (state_r == S_EVAL) && (!upd.fire || out_free);

  // result register takes a fire item or the summary item this cycle
  assign out_load = (eval_go && upd.fire) || ((state_r == S_SUM) && out_free);

  // fresh entry from a register item: due tick and run count start at zero
  always_comb begin
    new_entry.running  = in_data.run_enable;
    new_entry.interval = in_data.interval;
    new_entry.due_tick = '0;
    new_entry.runs     = '0;
  end

  // single write port shared by register items and scan write-back
  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = idx_r;
    ram_wdata = upd.entry;
    if (reg_acc && idx_in_range) begin
      ram_we    = 1'b1;
      ram_waddr = in_data.task_index[TASK_AW-1:0];
      ram_wdata = new_entry;
    end else if (eval_go && registered_r[idx_r]) begin
      ram_we = 1'b1;
    end
  end

  ptd_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (TASK_COUNT)
  ) u_table (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (state_r == S_READ),
    .raddr (idx_r),
    .rdata (ram_rdata)
  );

  ptd_entry_upd u_upd (
    .ent        (ram_rdata),
    .registered (registered_r[idx_r]),
    .wrap       (wrap_r),
    .prev_tick  (prev_tick_r),
    .tick       (tick_r),
    .upd        (upd)
  );

  // summary: distance from scan tick to the earliest due running entry
  always_comb begin
    if (!any_r) begin
      ttn = '1;
    end else if (earliest_r > tick_r) begin
      ttn = earliest_r - tick_r;
    end else begin
      ttn = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      registered_r <= '0;
      idx_r        <= '0;
      prev_tick_r  <= '0;
      wrap_r       <= 1'b0;
      any_r        <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      // a new result replaces one taken downstream
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        S_IDLE: begin
          if (reg_acc && idx_in_range) begin
            registered_r[in_data.task_index[TASK_AW-1:0]] <= 1'b1;
          end
          if (scan_acc) begin
            tick_r  <= in_data.scan_tick;
            wrap_r  <= prev_tick_r > in_data.scan_tick;
            idx_r   <= '0;
            any_r   <= 1'b0;
            state_r <= S_READ;
          end
        end
        S_READ: begin
          // read issued this cycle, data valid next
          state_r <= S_EVAL;
        end
        S_EVAL: begin
          if (eval_go) begin
            if (upd.fire) begin
              out_data_r.fired         <= 1'b1;
              out_data_r.fired_index   <= INDEX_W'(idx_r);
              out_data_r.run_count     <= upd.entry.runs;
              out_data_r.time_to_next  <= '0;
              out_data_r.last          <= 1'b0;
            end
            // earliest due tick among running entries, after rescheduling
            if (upd.counts && (!any_r || (upd.entry.due_tick < earliest_r))) begin
              earliest_r <= upd.entry.due_tick;
              any_r      <= 1'b1;
            end
            if (last_entry) begin
              state_r <= S_SUM;
            end else begin
              idx_r   <= idx_r + TASK_AW'(1);
              state_r <= S_READ;
            end
          end
        end
        S_SUM: begin
          if (out_free) begin
            out_data_r.fired         <= 1'b0;
            out_data_r.fired_index   <= '0;
            out_data_r.run_count     <= '0;
            out_data_r.time_to_next  <= ttn;
            out_data_r.last          <= 1'b1;
            prev_tick_r              <= tick_r;
            state_r                  <= S_IDLE;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

[src/ptd_ram.sv]
// generic single write port, single read port ram with registered read
// no dependencies
`timescale 1ns / 1ps

module ptd_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 8,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

[src/ptd_entry_upd.sv]
// per-entry update during a scan: wraparound fix, due test, reschedule
// depends on ptd_pkg
`timescale 1ns / 1ps

module ptd_entry_upd import ptd_pkg::*; (
  input  entry_t            ent,
  input  logic              registered,
  input  logic              wrap,
  input  logic [TICK_W-1:0] prev_tick,
  input  logic [TICK_W-1:0] tick,
  output upd_t              upd
);

  logic [TICK_W-1:0] due_fix;
  logic              fire;

  always_comb begin
    due_fix = ent.due_tick;
    if (wrap) begin
      if (ent.due_tick > prev_tick) begin
        due_fix = ent.due_tick - prev_tick;
      end else if (ent.due_tick > ent.interval) begin
        due_fix = '0;
      end
    end
  end

  assign fire = registered && ent.running && (tick > due_fix);

  always_comb begin
    upd.fire           = fire;
    upd.counts         = registered && ent.running;
    upd.entry.running  = ent.running;
    upd.entry.interval = ent.interval;
    upd.entry.due_tick = fire ? (tick + ent.interval) : due_fix;
    upd.entry.runs     = fire ? (ent.runs + TICK_W'(1)) : ent.runs;
  end

endmodule
